// File: hw/rtl/kcss_pkg.sv
package kcss_pkg;

    // Store depth and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int DATA_W   = 32;
    localparam int DIST_W   = DATA_W + 1;
    localparam int KEEP_W   = 5;
    localparam int CMP_W    = (KEEP_W > CNT_W) ? KEEP_W : CNT_W;

    // Register port
    localparam int ADDR_W   = 3;
    localparam int APB_W    = 32;

    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_KEEP   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB_V,
        ST_ABS_V,
        ST_RD,
        ST_SUB,
        ST_CMP,
        ST_PLACE,
        ST_EM_RD,
        ST_EM_OUT,
        ST_EM_NONE
    } kcss_state_t;

endpackage

// File: hw/rtl/kcss_in_if.sv
interface kcss_in_if;
    import kcss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     end_of_set;

    modport source (output valid, output value, output end_of_set, input ready);
    modport sink   (input valid, input value, input end_of_set, output ready);

endinterface

// File: hw/rtl/kcss_out_if.sv
interface kcss_out_if;
    import kcss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic                     last;
    logic                     none;

    modport source (output valid, output result_value, output last, output none,
                    input ready);
    modport sink   (input valid, input result_value, input last, input none,
                    output ready);

endinterface

// File: hw/rtl/k_closest_stream_select.sv
// Flow: an item is taken in and its distance to the target formed, then it is compared with
// kept entries in turn (read, subtract, compare; scan runs from the farthest entry inward)
// and placed behind the first that outranks it, or at the front. A value equal to the target
// drops in its accept cycle. No new item is taken until the last is done, as the subtract/compare
// unit and the value store are shared. End of set reads each result from the store, then offers it.
// Reset (rst_n low, async): store empty, target 0, keep_count 4, ready high on release.
module k_closest_stream_select
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kcss_pkg::ADDR_W-1:0]   paddr,
    input  logic [kcss_pkg::APB_W-1:0]    pwdata,
    output logic [kcss_pkg::APB_W-1:0]    prdata,
    output logic                          pready,

    kcss_in_if.sink                       in_ch,
    kcss_out_if.source                    out_ch
);
    import kcss_pkg::*;

    // Configuration
    logic signed [DATA_W-1:0] target_reg;
    logic [KEEP_W-1:0]        keep_reg;
    logic                     reg_sel;
    logic [CNT_W-1:0]         kcap;

    // Sequencer
    kcss_state_t              state_reg, state_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         newcnt_reg, newcnt_next;
    logic [CNT_W:0]           count_plus1;
    logic [CNT_W-1:0]         pos_plus1;

    // Item holding registers
    logic signed [DATA_W-1:0] v_reg;
    logic                     end_reg;
    logic                     load_item;

    // Shared subtract / absolute value / compare unit
    logic signed [DATA_W-1:0] sub_a;
    logic signed [DIST_W-1:0] diff_next, diff_reg;
    logic [DIST_W-1:0]        dist_abs;
    logic [DIST_W-1:0]        dv_reg;
    logic                     diff_en;
    logic                     dv_en;
    logic                     cand_closer;

    // Value store: one write port, one registered read port
    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;

    //------------------------------------------------------------------
    // Register port: writes land on the access cycle, reads are immediate
    //------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            keep_reg   <= KEEP_W'(4);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_TARGET: target_reg <= pwdata;
                REG_KEEP:   keep_reg   <= pwdata[KEEP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_TARGET: prdata = target_reg;
            REG_KEEP:   prdata = APB_W'(keep_reg);
            default:    prdata = '0;
        endcase
    end

    // Clamp keep_count to the store depth
    assign kcap = (CMP_W'(keep_reg) > CMP_W'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                         : CNT_W'(keep_reg);

    //------------------------------------------------------------------
    // Shared arithmetic: exact 33-bit difference, then magnitude and rank
    //------------------------------------------------------------------
    assign diff_next = DIST_W'(sub_a) - DIST_W'(target_reg);
    assign dist_abs  = diff_reg[DIST_W-1] ? DIST_W'(-diff_reg) : DIST_W'(diff_reg);

    // Candidate outranks the stored entry: smaller distance, or same distance
    // and larger value
    assign cand_closer = (dv_reg < dist_abs) ||
                         ((dv_reg == dist_abs) && (v_reg > rd_data_reg));

    assign count_plus1 = {1'b0, count_reg} + 1'b1;
    assign pos_plus1   = pos_reg + 1'b1;

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            count_reg  <= '0;
            newcnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            newcnt_reg <= newcnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        newcnt_next  = newcnt_reg;
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        load_item    = 1'b0;
        sub_a        = rd_data_reg;
        diff_en      = 1'b0;
        dv_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = pos_reg[IDX_W-1:0];
        mem_we       = 1'b0;
        mem_waddr    = pos_plus1[IDX_W-1:0];
        mem_wdata    = v_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    load_item = 1'b1;
                    if (in_ch.value != target_reg)
                    begin
                        // Size after insert; the farthest entry drops when over keep_count
                        newcnt_next = (count_plus1 > {1'b0, kcap}) ? count_reg
                                                                   : count_plus1[CNT_W-1:0];
                        state_next  = ST_SUB_V;
                    end
                    else if (in_ch.end_of_set)
                    begin
                        pos_next   = '0;
                        state_next = (count_reg == '0) ? ST_EM_NONE : ST_EM_RD;
                    end
                end
            end

            ST_SUB_V:
            begin
                sub_a      = v_reg;
                diff_en    = 1'b1;
                state_next = ST_ABS_V;
            end

            ST_ABS_V:
            begin
                dv_en = 1'b1;
                if (count_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    pos_next   = count_reg - 1'b1;
                    state_next = ST_RD;
                end
            end

            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_SUB;
            end

            ST_SUB:
            begin
                diff_en    = 1'b1;
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (cand_closer)
                begin
                    // Shift the entry one place outward, drop it past the new size
                    mem_wdata = rd_data_reg;
                    mem_we    = (pos_plus1 < newcnt_reg);
                    if (pos_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        pos_next   = pos_reg - 1'b1;
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    mem_we     = (pos_plus1 < newcnt_reg);
                    count_next = newcnt_reg;
                    pos_next   = '0;
                    if (end_reg)
                        state_next = (newcnt_reg == '0) ? ST_EM_NONE : ST_EM_RD;
                    else
                        state_next = ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                mem_waddr  = '0;
                mem_we     = (newcnt_reg != '0);
                count_next = newcnt_reg;
                pos_next   = '0;
                if (end_reg)
                    state_next = (newcnt_reg == '0) ? ST_EM_NONE : ST_EM_RD;
                else
                    state_next = ST_IDLE;
            end

            ST_EM_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_EM_OUT;
            end

            ST_EM_OUT:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                begin
                    if (pos_plus1 == count_reg)
                    begin
                        count_next = '0;
                        pos_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_plus1;
                        state_next = ST_EM_RD;
                    end
                end
            end

            ST_EM_NONE:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result payload holds from registers while the transfer stalls
    assign out_ch.result_value = (state_reg == ST_EM_OUT) ? rd_data_reg : '0;
    assign out_ch.last         = (state_reg == ST_EM_NONE) || (pos_plus1 == count_reg);
    assign out_ch.none         = (state_reg == ST_EM_NONE);

    //------------------------------------------------------------------
    // Datapath registers
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            v_reg   <= in_ch.value;
            end_reg <= in_ch.end_of_set;
        end
        if (diff_en)
            diff_reg <= diff_next;
        if (dv_en)
            dv_reg <= dist_abs;
    end

    //------------------------------------------------------------------
    // Value store
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule
